// File: rtl/clipped_alpha_blit_core_assert.svh
// Assertion macros for the port-level checker of the blit core.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef CLIPPED_ALPHA_BLIT_CORE_ASSERT_SVH
`define CLIPPED_ALPHA_BLIT_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CAB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define CAB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/cab_pkg.sv
`timescale 1ns / 1ps

package cab_pkg;

	// Field widths.
	localparam int REG_W     = 13;
	localparam int CFG_IDX_W = 3;
	localparam int TGT_W     = 12;
	localparam int PIX_W     = 32;
	localparam int CH_W      = 8;

	// Default bitmap size limit.
	localparam int unsigned MAX_DIM_DEF = 4096;

	// Frame clip edges saturate at the reach of the target fields.
	localparam logic [REG_W-1:0] FRAME_LIMIT = REG_W'(1 << TGT_W);

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X      = 3'd0,
		REG_ORIGIN_Y      = 3'd1,
		REG_BITMAP_WIDTH  = 3'd2,
		REG_BITMAP_HEIGHT = 3'd3,
		REG_FRAME_WIDTH   = 3'd4,
		REG_FRAME_HEIGHT  = 3'd5
	} cab_reg_t;

	// Register file contents.
	typedef struct packed {
		logic [REG_W-1:0] origin_x;
		logic [REG_W-1:0] origin_y;
		logic [REG_W-1:0] bmp_w;
		logic [REG_W-1:0] bmp_h;
		logic [REG_W-1:0] frm_w;
		logic [REG_W-1:0] frm_h;
	} cab_cfg_t;

	localparam cab_cfg_t CFG_RESET = '{
		origin_x: '0,
		origin_y: '0,
		bmp_w:    REG_W'(1),
		bmp_h:    REG_W'(1),
		frm_w:    REG_W'(1),
		frm_h:    REG_W'(1)
	};

	// Placement of one pixel in the frame.
	typedef struct packed {
		logic [TGT_W-1:0] tx;
		logic [TGT_W-1:0] ty;
		logic             we;
		logic             last;
	} cab_geo_t;

endpackage

// File: rtl/cab_if.sv
`timescale 1ns / 1ps

// Pixel pair entering the blitter.
interface cab_in_if;
	import cab_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] source_pixel;
	logic [PIX_W-1:0] dest_pixel;

	modport source (output valid, source_pixel, dest_pixel, input ready);
	modport sink (input valid, source_pixel, dest_pixel, output ready);
endinterface

// Blended pixel and its frame placement.
interface cab_out_if;
	import cab_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] blended_pixel;
	logic [TGT_W-1:0] target_x;
	logic [TGT_W-1:0] target_y;
	logic             write_enable;
	logic             last_pixel;

	modport source (output valid, blended_pixel, target_x, target_y, write_enable,
		last_pixel, input ready);
	modport sink (input valid, blended_pixel, target_x, target_y, write_enable,
		last_pixel, output ready);
endinterface

// Register write channel.
interface cab_cfg_if;
	import cab_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [REG_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/clipped_alpha_blit_core.sv
`timescale 1ns / 1ps
// An accepted input word is held in the input register, then in the result register.
// Throughput: one word per cycle; the input register and the result register form
// a two-stage pipeline stalled only by backpressure on the output.
// Reset: asynchronous, active low; clears both pipeline stages and the column and
// row counters, and sets the origins to 0 and all sizes to 1.

module clipped_alpha_blit_core #(
	parameter int unsigned MAX_DIM = cab_pkg::MAX_DIM_DEF
) (
	input logic        clk,
	input logic        arst_n,
	cab_cfg_if.sink    cfg,
	cab_in_if.sink     pix_in,
	cab_out_if.source  pix_out
);
	import cab_pkg::*;

	cab_cfg_t         cfg_q;
	cab_geo_t         geo;
	cab_geo_t         geo_s1;
	logic [PIX_W-1:0] src_s1;
	logic [PIX_W-1:0] dst_s1;
	logic             v_s1;
	logic [PIX_W-1:0] pixel;
	logic [PIX_W-1:0] pix_s2;
	cab_geo_t         geo_s2;
	logic             v_s2;
	logic             s2_load;
	logic             s1_free;
	logic             accept;

	// Register writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cab_reg_t'(cfg.index))
				REG_ORIGIN_X:      cfg_q.origin_x <= cfg.data;
				REG_ORIGIN_Y:      cfg_q.origin_y <= cfg.data;
				REG_BITMAP_WIDTH:  cfg_q.bmp_w    <= cfg.data;
				REG_BITMAP_HEIGHT: cfg_q.bmp_h    <= cfg.data;
				REG_FRAME_WIDTH:   cfg_q.frm_w    <= cfg.data;
				REG_FRAME_HEIGHT:  cfg_q.frm_h    <= cfg.data;
				default: ;
			endcase
		end
	end

	// Pipeline flow control.
	assign s2_load      = !v_s2 || pix_out.ready;
	assign s1_free      = !v_s1 || s2_load;
	assign pix_in.ready = s1_free;
	assign accept       = pix_in.valid && s1_free;

	cab_walk #(
		.MAX_DIM(MAX_DIM)
	) u_walk (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_q),
		.step  (accept),
		.geo   (geo)
	);

	// Input stage: pixels and their placement.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_free) begin
			v_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			src_s1 <= pix_in.source_pixel;
			dst_s1 <= pix_in.dest_pixel;
			geo_s1 <= geo;
		end
	end

	cab_blend u_blend (
		.src  (src_s1),
		.dst  (dst_s1),
		.we   (geo_s1.we),
		.pixel(pixel)
	);

	// Result stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_load) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load && v_s1) begin
			pix_s2 <= pixel;
			geo_s2 <= geo_s1;
		end
	end

	assign pix_out.valid         = v_s2;
	assign pix_out.blended_pixel = pix_s2;
	assign pix_out.target_x      = geo_s2.tx;
	assign pix_out.target_y      = geo_s2.ty;
	assign pix_out.write_enable  = geo_s2.we;
	assign pix_out.last_pixel    = geo_s2.last;

endmodule

// File: rtl/cab_walk.sv
`timescale 1ns / 1ps

// Column and row walk over the bitmap, with frame placement and clipping.
module cab_walk #(
	parameter int unsigned MAX_DIM = cab_pkg::MAX_DIM_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cab_pkg::cab_cfg_t cfg,
	input  logic              step,
	output cab_pkg::cab_geo_t geo
);
	import cab_pkg::*;

	localparam int CNT_W  = $clog2(MAX_DIM);
	localparam int DIM_LW = $clog2(MAX_DIM + 1);
	localparam int DIM_W  = ((DIM_LW > REG_W) ? DIM_LW : REG_W) + 1;
	localparam int GW     = (((CNT_W + 1) > REG_W) ? (CNT_W + 1) : REG_W) + 1;
	localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

	// A bitmap size of zero acts as one; sizes above the limit saturate.
	function automatic logic [DIM_W-1:0] bmp_dim(input logic [REG_W-1:0] v);
		logic [DIM_W-1:0] w;
		w = DIM_W'(v);
		if (w == '0)
			return DIM_W'(1);
		if (w > DIM_MAX)
			return DIM_MAX;
		return w;
	endfunction

	function automatic logic [REG_W-1:0] frm_dim(input logic [REG_W-1:0] v);
		return (v > FRAME_LIMIT) ? FRAME_LIMIT : v;
	endfunction

	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;
	logic [DIM_W-1:0] bw;
	logic [DIM_W-1:0] bh;
	logic [DIM_W-1:0] col_nx;
	logic [DIM_W-1:0] row_nx;
	logic             end_col;
	logic             end_row;
	logic             last;
	logic [GW-1:0]    tx;
	logic [GW-1:0]    ty;
	logic             in_x;
	logic             in_y;

	// End of row and end of bitmap; a counter past a shrunk size wraps at once.
	always_comb begin
		bw      = bmp_dim(cfg.bmp_w);
		bh      = bmp_dim(cfg.bmp_h);
		col_nx  = DIM_W'(col_q) + DIM_W'(1);
		row_nx  = DIM_W'(row_q) + DIM_W'(1);
		end_col = col_nx >= bw;
		end_row = row_nx >= bh;
		last    = end_col & end_row;
	end

	// Target spot and clip test against the frame.
	always_comb begin
		tx   = {{(GW - REG_W){cfg.origin_x[REG_W-1]}}, cfg.origin_x} + GW'(col_q);
		ty   = {{(GW - REG_W){cfg.origin_y[REG_W-1]}}, cfg.origin_y} + GW'(row_q);
		in_x = !tx[GW-1] && (tx < GW'(frm_dim(cfg.frm_w)));
		in_y = !ty[GW-1] && (ty < GW'(frm_dim(cfg.frm_h)));
		geo.we   = in_x & in_y;
		geo.tx   = geo.we ? tx[TGT_W-1:0] : '0;
		geo.ty   = geo.we ? ty[TGT_W-1:0] : '0;
		geo.last = last;
	end

	// Counters advance once per accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			if (last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (end_col) begin
				col_q <= '0;
				row_q <= row_nx[CNT_W-1:0];
			end else begin
				col_q <= col_nx[CNT_W-1:0];
			end
		end
	end

endmodule

// File: rtl/cab_blend.sv
`timescale 1ns / 1ps

// Per-channel alpha blend of one pixel; destination alpha is kept.
module cab_blend (
	input  logic [cab_pkg::PIX_W-1:0] src,
	input  logic [cab_pkg::PIX_W-1:0] dst,
	input  logic                      we,
	output logic [cab_pkg::PIX_W-1:0] pixel
);
	import cab_pkg::*;

	localparam int NCH = 3;
	localparam int NW  = 2 * CH_W;

	// Rounded n/255 via the add-back reciprocal: t = n + 128, (t + t/256) / 256.
	function automatic logic [CH_W-1:0] blend_ch(
		input logic [CH_W-1:0] a,
		input logic [CH_W-1:0] s,
		input logic [CH_W-1:0] d
	);
		logic [NW-1:0] n;
		logic [NW:0]   t;
		logic [NW:0]   q;
		n = (NW'({CH_W{1'b1}}) - NW'(a)) * NW'(d) + NW'(a) * NW'(s);
		t = (NW + 1)'(n) + (NW + 1)'(1 << (CH_W - 1));
		q = t + (t >> CH_W);
		return q[NW-1:CH_W];
	endfunction

	logic [CH_W-1:0] alpha;
	logic [CH_W-1:0] ch [NCH];

	assign alpha = src[PIX_W-1 -: CH_W];

	// Red, green and blue lanes work side by side.
	for (genvar i = 0; i < NCH; i++) begin : g_ch
		assign ch[i] = blend_ch(alpha, src[i*CH_W +: CH_W], dst[i*CH_W +: CH_W]);
	end

	// Clipped spots carry an all-zero word.
	always_comb begin
		pixel = '0;
		if (we) begin
			pixel[PIX_W-1 -: CH_W] = dst[PIX_W-1 -: CH_W];
			for (int i = 0; i < NCH; i++)
				pixel[i*CH_W +: CH_W] = ch[i];
		end
	end

endmodule

// File: rtl/cab_checker.sv
`timescale 1ns / 1ps
`include "clipped_alpha_blit_core_assert.svh"

// Port-level checks of the blit core.
module cab_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [cab_pkg::PIX_W-1:0] out_pixel,
	input logic [cab_pkg::TGT_W-1:0] out_tx,
	input logic [cab_pkg::TGT_W-1:0] out_ty,
	input logic                      out_we
);
	logic in_acc;

	assign in_acc = in_valid && in_ready;

	// A clipped word carries zero pixel and zero coordinates.
	`CAB_ASSERT_NOW(a_clip_zero, out_valid && !out_we,
		out_pixel == '0 && out_tx == '0 && out_ty == '0, "clipped word not zeroed")

	// A stalled word holds.
	`CAB_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
		out_valid && $stable(out_pixel) && $stable(out_tx) && $stable(out_ty),
		"stalled word changed")

	// From an empty pipeline a word appears once its input has passed the input and result registers.
	`CAB_ASSERT_NOW(a_latency, $rose(out_valid), $past(in_acc, 2),
		"result without matching input")

endmodule

bind clipped_alpha_blit_core cab_checker u_cab_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (pix_in.valid),
	.in_ready (pix_in.ready),
	.out_valid(pix_out.valid),
	.out_ready(pix_out.ready),
	.out_pixel(pix_out.blended_pixel),
	.out_tx   (pix_out.target_x),
	.out_ty   (pix_out.target_y),
	.out_we   (pix_out.write_enable)
);

// File: tb/sv/blit_checker.sv
`timescale 1ns / 1ps

// Watches the three channels of the blit core, predicts the placement and
// blend of every accepted pixel word and compares each result word in order.
module blit_checker #(
	parameter int unsigned MAX_DIM = cab_pkg::MAX_DIM_DEF
) (
	input  logic clk,
	input  logic arst_n,
	cab_cfg_if   cfg_mon,
	cab_in_if    in_mon,
	cab_out_if   out_mon,
	output int   fail_total,
	output int   words_in_flight
);
	import cab_pkg::*;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [TGT_W-1:0] tx;
		logic [TGT_W-1:0] ty;
		logic             we;
		logic             last;
	} blit_word_t;

	cab_cfg_t         geometry;
	logic [TGT_W-1:0] column_pos;
	logic [TGT_W-1:0] row_pos;
	blit_word_t       pending_blits[$];
	int               mismatches = 0;
	int               queued = 0;

	assign fail_total = mismatches;
	assign words_in_flight = queued;

	// A bitmap size of zero acts as one; sizes above the limit saturate.
	function automatic int unsigned bitmap_extent(input logic [REG_W-1:0] raw);
		if (raw == '0)
			return 1;
		if (raw > MAX_DIM)
			return MAX_DIM;
		return raw;
	endfunction

	// Frame sizes saturate at the reach of the target coordinates.
	function automatic int unsigned frame_extent(input logic [REG_W-1:0] raw);
		return (raw > FRAME_LIMIT) ? FRAME_LIMIT : raw;
	endfunction

	// Places one pixel, blends it when it lands inside the frame, and advances
	// the column and row position.
	function automatic blit_word_t blit_pixel(input logic [PIX_W-1:0] src,
		input logic [PIX_W-1:0] dst);
		blit_word_t  res;
		int unsigned bw, bh, fw, fh, alpha, mix;
		int          tx, ty;
		logic        on_frame, end_col, end_row;
		bw = bitmap_extent(geometry.bmp_w);
		bh = bitmap_extent(geometry.bmp_h);
		fw = frame_extent(geometry.frm_w);
		fh = frame_extent(geometry.frm_h);
		tx = int'($signed(geometry.origin_x)) + int'(column_pos);
		ty = int'($signed(geometry.origin_y)) + int'(row_pos);
		on_frame = tx >= 0 && ty >= 0 && tx < int'(fw) && ty < int'(fh);
		end_col = int'(column_pos) + 1 >= int'(bw);
		end_row = int'(row_pos) + 1 >= int'(bh);
		res = '0;
		res.last = end_col && end_row;
		if (on_frame) begin
			alpha = src[31:24];
			for (int ch = 0; ch < 3; ch++) begin
				mix = (255 - alpha) * dst[CH_W*ch +: CH_W] + alpha * src[CH_W*ch +: CH_W];
				mix = (2 * mix + 255) / 510;
				res.pixel[CH_W*ch +: CH_W] = mix[CH_W-1:0];
			end
			res.pixel[31:24] = dst[31:24];
			res.tx = tx[TGT_W-1:0];
			res.ty = ty[TGT_W-1:0];
			res.we = 1'b1;
		end
		if (res.last) begin
			column_pos = '0;
			row_pos = '0;
		end else if (end_col) begin
			column_pos = '0;
			row_pos = row_pos + 1'b1;
		end else begin
			column_pos = column_pos + 1'b1;
		end
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 100)
			$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	task automatic compare_field(input string name, input logic [PIX_W-1:0] got,
		input logic [PIX_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h, predicted %0h", name, got, want));
	endtask

	// Register writes, pixel words and result words are handled at the same edge
	// in a fixed order.
	always @(posedge clk or negedge arst_n) begin : watch
		blit_word_t want;
		if (!arst_n) begin
			geometry = CFG_RESET;
			column_pos = '0;
			row_pos = '0;
			pending_blits.delete();
			queued = 0;
		end else begin
			if (cfg_mon.valid && cfg_mon.ready) begin
				case (cab_reg_t'(cfg_mon.index))
					REG_ORIGIN_X:      geometry.origin_x = cfg_mon.data;
					REG_ORIGIN_Y:      geometry.origin_y = cfg_mon.data;
					REG_BITMAP_WIDTH:  geometry.bmp_w = cfg_mon.data;
					REG_BITMAP_HEIGHT: geometry.bmp_h = cfg_mon.data;
					REG_FRAME_WIDTH:   geometry.frm_w = cfg_mon.data;
					REG_FRAME_HEIGHT:  geometry.frm_h = cfg_mon.data;
					default: ;
				endcase
			end
			if (in_mon.valid && in_mon.ready)
				pending_blits.push_back(blit_pixel(in_mon.source_pixel, in_mon.dest_pixel));
			if (out_mon.valid && out_mon.ready) begin
				if (pending_blits.size() == 0) begin
					report_mismatch($sformatf("result word %0h with no pixel word pending",
						out_mon.blended_pixel));
				end else begin
					want = pending_blits.pop_front();
					compare_field("blended_pixel", out_mon.blended_pixel, want.pixel);
					compare_field("target_x", out_mon.target_x, want.tx);
					compare_field("target_y", out_mon.target_y, want.ty);
					compare_field("write_enable", out_mon.write_enable, want.we);
					compare_field("last_pixel", out_mon.last_pixel, want.last);
				end
			end
			queued = pending_blits.size();
		end
	end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import cab_pkg::*;

	localparam int TOTAL_ITEMS = 1870;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n;

	cab_cfg_if cfg_if();
	cab_in_if  in_if();
	cab_out_if out_if();

	int fail_total;
	int words_in_flight;
	int items_sent = 0;
	int quiet_cycles = 0;
	bit in_gaps_on = 1'b1;
	bit out_gaps_on = 1'b1;
	bit hold_req = 1'b0;
	bit hold_served = 1'b0;

	always #2 clk = ~clk;

	clipped_alpha_blit_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_if),
		.pix_in  (in_if),
		.pix_out (out_if)
	);

	blit_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_mon         (cfg_if),
		.in_mon          (in_if),
		.out_mon         (out_if),
		.fail_total      (fail_total),
		.words_in_flight (words_in_flight)
	);

	// Offers one pixel word, possibly after some idle cycles, and waits until
	// it is taken.
	task automatic push_word(input logic [PIX_W-1:0] src, input logic [PIX_W-1:0] dst);
		if (in_gaps_on) begin
			while ($urandom_range(99) < 28) begin
				in_if.valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_if.valid <= 1'b1;
		in_if.source_pixel <= src;
		in_if.dest_pixel <= dst;
		items_sent++;
		do @(posedge clk); while (!in_if.ready);
	endtask

	// Stops offering words and waits until every predicted result has come.
	task automatic drain();
		in_if.valid <= 1'b0;
		@(posedge clk);
		while (words_in_flight != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input cab_reg_t idx, input int raw);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= REG_W'(raw);
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Registers are only rewritten once the pipeline is empty.
	task automatic set_geometry(input int ox, input int oy, input int bw, input int bh,
		input int fw, input int fh);
		drain();
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_BITMAP_WIDTH, bw);
		write_reg(REG_BITMAP_HEIGHT, bh);
		write_reg(REG_FRAME_WIDTH, fw);
		write_reg(REG_FRAME_HEIGHT, fh);
	endtask

	// Alpha is biased toward fully transparent and fully opaque.
	function automatic logic [PIX_W-1:0] random_source();
		logic [PIX_W-1:0] word;
		word = $urandom();
		case ($urandom_range(3))
			0: word[31:24] = 8'h00;
			1: word[31:24] = 8'hFF;
			default: ;
		endcase
		return word;
	endfunction

	// Origins are raw 13 bit codes: mostly near the frame, sometimes extreme.
	function automatic int pick_origin();
		int offset;
		case ($urandom_range(9))
			0: return 'h1000;
			1: return 'h0FFF;
			2, 3: return $urandom_range(8191);
			default: begin
				offset = int'($urandom_range(40)) - 16;
				return offset & 8191;
			end
		endcase
	endfunction

	function automatic int pick_bitmap_extent();
		case ($urandom_range(4))
			0: return 0;
			1: return 8191;
			2: return 4096;
			default: return $urandom_range(8191);
		endcase
	endfunction

	function automatic int pick_frame_extent();
		case ($urandom_range(11))
			0: return 0;
			1: return 8191;
			2: return 4096;
			3: return $urandom_range(8191);
			default: return $urandom_range(1, 40);
		endcase
	endfunction

	// Result side: random stalls, a quiet stretch, and one long hold-off that
	// backs the block up into its input.
	initial begin : result_sink
		out_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_served) begin
				hold_served = 1'b1;
				out_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (out_gaps_on) begin
				out_if.ready <= ($urandom_range(99) >= 28);
			end else begin
				out_if.ready <= 1'b1;
			end
		end
	end

	// The run ends with a failure if no word moves on any channel for too long.
	always @(posedge clk) begin
		if ((cfg_if.valid && cfg_if.ready) || (in_if.valid && in_if.ready)
			|| (out_if.valid && out_if.ready)) begin
			quiet_cycles = 0;
		end else if (arst_n) begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int  phase_no;
		int  bw, bh, n;
		bit  compact, quiet;
		arst_n <= 1'b0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= REG_ORIGIN_X;
		cfg_if.data <= '0;
		in_if.valid <= 1'b0;
		in_if.source_pixel <= '0;
		in_if.dest_pixel <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset geometry: a single pixel bitmap on a single pixel frame, so every
		// word is written and is the last one. Alpha at both ends and halfway.
		push_word(32'h00123456, 32'hAB654321);
		push_word(32'hFF89ABCD, 32'h00FEDCBA);
		push_word(32'h80FF00FF, 32'h7F00FF80);
		push_word(32'hFFFFFFFF, 32'hFFFFFFFF);
		push_word(32'h00000000, 32'h00000000);

		// Most negative column, largest row, zero bitmap width, oversized height
		// and an empty frame: every spot is clipped.
		set_geometry('h1000, 'h0FFF, 0, 8191, 0, 0);
		push_word(32'hFFFFFFFF, 32'hFFFFFFFF);
		push_word(32'h80A5A5A5, 32'h5A5A5A5A);
		push_word(32'hFF123456, 32'h89ABCDEF);

		// Shrinking the height mid-bitmap wraps at once; then the far corner of
		// an oversized frame is reachable and everything past it is clipped.
		set_geometry('h0FFF, 'h0FFF, 2, 2, 8191, 4096);
		push_word(32'hFF102030, 32'h40506070);
		push_word(32'hFF102030, 32'h40506070);
		push_word(32'h7F808080, 32'hC0FFFFFF);
		push_word(32'h01FFFFFF, 32'h00000000);
		push_word(32'hFE000000, 32'hFFFFFFFF);

		// Left edge one column off the frame, frame exactly at the limit.
		set_geometry('h1FFF, 0, 3, 3, 4096, 2);
		push_word(32'hFF0000FF, 32'h12345678);
		push_word(32'h40FF8000, 32'h87654321);
		push_word(32'hC0123456, 32'hFEDCBA98);
		push_word(32'h20ABCDEF, 32'h0F0F0F0F);

		// Shrinking to one pixel mid-row makes the next word the last one.
		set_geometry('h1FFF, 0, 1, 1, 4096, 2);
		push_word(32'hFFF0F0F0, 32'h11111111);
		push_word(32'h00F0F0F0, 32'h22222222);

		// Random geometry phases, mostly whole small bitmaps, some cut short.
		phase_no = 0;
		while (items_sent < TOTAL_ITEMS) begin
			quiet = phase_no >= 6 && phase_no < 12;
			in_gaps_on = !quiet;
			out_gaps_on = !quiet;
			compact = $urandom_range(99) < 85;
			if (compact) begin
				bw = $urandom_range(1, 12);
				bh = $urandom_range(1, 10);
			end else begin
				bw = pick_bitmap_extent();
				bh = pick_bitmap_extent();
			end
			set_geometry(pick_origin(), pick_origin(), bw, bh, pick_frame_extent(),
				pick_frame_extent());
			if (!compact) begin
				n = $urandom_range(1, 60);
			end else if ($urandom_range(99) < 15) begin
				n = $urandom_range(1, bw * bh);
			end else begin
				n = bw * bh * $urandom_range(1, 3);
				if (n > 200)
					n = bw * bh;
			end
			if (phase_no == 2) begin
				hold_req = 1'b1;
				if (n < 80)
					n = 80;
			end
			repeat (n) push_word(random_source(), $urandom());
			phase_no++;
		end

		drain();
		repeat (10) @(posedge clk);
		if (fail_total == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
